// File: design/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 13;
  localparam int unsigned CpW     = 16;

  localparam logic [CountW-1:0] LimitReset = 13'd142;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_LIMIT    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ONE  = 2'd1,
    PEND_TWO  = 2'd2
  } pend_e;

  typedef struct packed {
    kind_e              result_kind;
    logic [ByteW-1:0]   data_byte;
    logic [CountW-1:0]  byte_count;
    status_e            stop_status;
    logic               last_of_run;
  } result_t;

endpackage

// File: design/u8u2_stream_if.sv
// ----------------------------------------------------------------------------
// u8u2 stream interfaces
// Valid/ready channels for UTF-8 input words and UCS-2 result words.
// ----------------------------------------------------------------------------
interface u8u2_text_if;
  logic                        valid;
  logic                        ready;
  logic [u8u2_pkg::ByteW-1:0]  text_byte;
  logic                        end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8u2_ucs_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [u8u2_pkg::ByteW-1:0]   data_byte;
  logic [u8u2_pkg::CountW-1:0]  byte_count;
  logic [1:0]                   stop_status;
  logic                         last_of_run;

  modport source (output valid, output result_kind, output data_byte, output byte_count,
                  output stop_status, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input byte_count,
                  input stop_status, input last_of_run, output ready);
endinterface

// File: design/utf8_to_ucs2_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder
// Decodes a UTF-8 byte stream into big-endian UCS-2 bytes with a status report.
// ----------------------------------------------------------------------------
// Usage:
//   text_i carries one UTF-8 word per handshake; a word with end_of_text set
//   closes the text and yields one completion report (status, byte count).
//   ucs_o carries result words: data bytes (high byte of a code point, then
//   low byte) and completion reports. last_of_run marks the final result word
//   caused by an input word.
//   A result is registered and appears on ucs_o in the cycle after the word
//   that causes it is taken. A completed code point gives two result words,
//   the low byte waiting in the holding register; every other word gives
//   at most one. Throughput: one input word per cycle while it yields at
//   most one result and ucs_o does not stall; input waits while the low
//   byte sits in the holding register behind the single output register.
//   cfg_we_i / cfg_wdata_i write the output limit (reset value 142).
//   Reset clears the decode state and empties both output registers.
//   When the receiver stalls, the output word holds and text_i.ready drops
//   until it is taken; it also drops while the holding register is occupied.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [u8u2_pkg::CountW-1:0]  cfg_wdata_i,
  u8u2_text_if.sink                    text_i,
  u8u2_ucs_if.source                   ucs_o
);

  logic [u8u2_pkg::CountW-1:0] limit_q;
  u8u2_pkg::pend_e             pend_q, pend_d;
  logic [u8u2_pkg::CpW-1:0]    cp_q, cp_d;
  logic                        stopped_q, stopped_d;
  u8u2_pkg::status_e           status_q, status_d;
  logic [u8u2_pkg::CountW-1:0] count_q, count_d;

  logic                        out_valid_q;
  u8u2_pkg::result_t           out_q;
  logic                        hold_valid_q;
  u8u2_pkg::result_t           hold_q;

  logic                        out_free;
  logic                        accept;
  logic                        res_any;
  logic                        res_two;
  u8u2_pkg::result_t           res0, res1;
  logic [u8u2_pkg::CpW-1:0]    cp_done;
  logic [u8u2_pkg::CountW:0]   count_next;
  logic [u8u2_pkg::ByteW-1:0]  b;

  assign out_free     = !out_valid_q || ucs_o.ready;
  assign text_i.ready = !hold_valid_q && out_free;
  assign accept       = text_i.valid && text_i.ready;
  assign b            = text_i.text_byte;
  assign count_next   = {1'b0, count_q} + {{u8u2_pkg::CountW{1'b0}}, 1'b1};

  always_comb begin
    pend_d    = pend_q;
    cp_d      = cp_q;
    stopped_d = stopped_q;
    status_d  = status_q;
    count_d   = count_q;
    res_any   = 1'b0;
    res_two   = 1'b0;
    cp_done   = '0;
    res0      = '{result_kind: u8u2_pkg::KIND_DATA, data_byte: '0, byte_count: '0,
                  stop_status: u8u2_pkg::ST_OK, last_of_run: 1'b0};
    res1      = res0;
    if (accept) begin
      if (text_i.end_of_text) begin
        res_any          = 1'b1;
        res0.result_kind = u8u2_pkg::KIND_REPORT;
        res0.byte_count  = count_q;
        res0.stop_status = (!stopped_q && pend_q != u8u2_pkg::PEND_NONE) ?
                           u8u2_pkg::ST_TRUNC : status_q;
        res0.last_of_run = 1'b1;
        pend_d    = u8u2_pkg::PEND_NONE;
        cp_d      = '0;
        stopped_d = 1'b0;
        status_d  = u8u2_pkg::ST_OK;
        count_d   = '0;
      end else if (!stopped_q) begin
        unique case (pend_q)
          u8u2_pkg::PEND_TWO: begin
            cp_d   = cp_q | {4'b0, b[5:0], 6'b0};
            pend_d = u8u2_pkg::PEND_ONE;
          end
          u8u2_pkg::PEND_ONE: begin
            cp_done = cp_q | {10'b0, b[5:0]};
            res_any = 1'b1;
            pend_d  = u8u2_pkg::PEND_NONE;
            cp_d    = '0;
          end
          default: begin
            if (count_next >= {1'b0, limit_q}) begin
              stopped_d = 1'b1;
              status_d  = u8u2_pkg::ST_LIMIT;
              cp_d      = '0;
            end else if (!b[7]) begin
              cp_done = {8'b0, b};
              res_any = 1'b1;
            end else if (b[7:5] == 3'b110) begin
              cp_d   = {5'b0, b[4:0], 6'b0};
              pend_d = u8u2_pkg::PEND_ONE;
            end else if (b[7:4] == 4'b1110) begin
              cp_d   = {b[3:0], 12'b0};
              pend_d = u8u2_pkg::PEND_TWO;
            end else begin
              stopped_d = 1'b1;
              status_d  = u8u2_pkg::ST_BAD_LEAD;
              cp_d      = '0;
            end
          end
        endcase
        if (res_any) begin
          res_two          = 1'b1;
          res0.data_byte   = cp_done[15:8];
          res1.data_byte   = cp_done[7:0];
          res1.last_of_run = 1'b1;
          count_d          = count_q + u8u2_pkg::CountW'(2);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= u8u2_pkg::LimitReset;
      pend_q    <= u8u2_pkg::PEND_NONE;
      cp_q      <= '0;
      stopped_q <= 1'b0;
      status_q  <= u8u2_pkg::ST_OK;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      pend_q    <= pend_d;
      cp_q      <= cp_d;
      stopped_q <= stopped_d;
      status_q  <= status_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else if (hold_valid_q && out_free) begin
      out_valid_q  <= 1'b1;
      hold_valid_q <= 1'b0;
    end else if (accept && res_any) begin
      out_valid_q  <= 1'b1;
      hold_valid_q <= res_two;
    end else if (out_free) begin
      out_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_valid_q && out_free) begin
      out_q <= hold_q;
    end else if (accept && res_any) begin
      out_q  <= res0;
      hold_q <= res1;
    end
  end

  assign ucs_o.valid       = out_valid_q;
  assign ucs_o.result_kind = out_q.result_kind;
  assign ucs_o.data_byte   = out_q.data_byte;
  assign ucs_o.byte_count  = out_q.byte_count;
  assign ucs_o.stop_status = out_q.stop_status;
  assign ucs_o.last_of_run = out_q.last_of_run;

endmodule
